[design/harsh_accel_brake_detector_assert.svh]
// Assertion macros for the checker file of the harsh braking detector.
// No dependencies; include by bare file name inside a module body.
`ifndef HARSH_ACCEL_BRAKE_DETECTOR_ASSERT_SVH
`define HARSH_ACCEL_BRAKE_DETECTOR_ASSERT_SVH

// Checked property with reset masking.
`define HABD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define HABD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/habd_pkg.sv]
// Types and constants of the harsh braking / acceleration detector.
// No dependencies; imported by the detector, the result queue and the top level.
`default_nettype none

package habd_pkg;

   typedef enum logic {
      KIND_BRAKE = 1'b0,
      KIND_ACCEL = 1'b1
   } event_kind_type;

   typedef enum logic [1:0] {
      REG_BRAKE_START   = 2'd0,
      REG_BRAKE_RELEASE = 2'd1,
      REG_ACCEL_START   = 2'd2,
      REG_ACCEL_RELEASE = 2'd3
   } reg_index_type;

   localparam logic signed [15:0] BRAKE_START_RESET   = -16'sd768;
   localparam logic signed [15:0] BRAKE_RELEASE_RESET = -16'sd512;
   localparam logic signed [15:0] ACCEL_START_RESET   = 16'sd768;
   localparam logic signed [15:0] ACCEL_RELEASE_RESET = 16'sd512;

   localparam logic [15:0] TICK_LIMIT = 16'd65533;
   localparam logic [22:0] TICK_MS    = 23'd100;

   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_W     = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W     = $clog2(RSP_DEPTH + 1);

   // what one detector reports on the cycle an episode closes
   typedef struct packed {
      logic        fire;
      logic [22:0] duration_ms;
      logic [9:0]  start_speed;
   } det_event_type;

   typedef struct packed {
      event_kind_type kind;
      logic [22:0]    duration_ms;
      logic [9:0]     start_speed;
      logic [9:0]     end_speed;
      logic           last_event;
   } rsp_entry_type;

   typedef struct packed {
      logic          push0;
      rsp_entry_type entry0;
      logic          push1;
      rsp_entry_type entry1;
   } rsp_push_type;

endpackage

`default_nettype wire

[design/habd_detector.sv]
// One hysteresis episode detector (braking or acceleration, chosen by kind).
// Depends on habd_pkg.
`default_nettype none

module habd_detector (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  habd_pkg::event_kind_type     kind,
   input  wire logic                    proc,
   input  wire logic signed [15:0]      accel_sample,
   input  wire logic [9:0]              speed,
   input  wire logic signed [15:0]      start_level,
   input  wire logic signed [15:0]      release_level,
   output habd_pkg::det_event_type      evt
);
   import habd_pkg::*;

   logic        active_ff, active_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [9:0]  start_speed_ff, start_speed_in;
   logic        start_hit, hold_hit, emit_ok;
   logic [15:0] ticks_p2;

   always_comb begin
      if (kind == KIND_ACCEL) begin
         start_hit = accel_sample >= start_level;
         hold_hit  = accel_sample >= release_level;
         emit_ok   = speed > start_speed_ff;
      end else begin
         start_hit = accel_sample <= start_level;
         hold_hit  = accel_sample <= release_level;
         // speed must fall by more than one
         emit_ok   = {1'b0, start_speed_ff} > ({1'b0, speed} + 11'd1);
      end

      ticks_p2        = ticks_ff + 16'd2;
      evt.fire        = 1'b0;
      evt.duration_ms = {7'd0, ticks_p2} * TICK_MS;
      evt.start_speed = start_speed_ff;

      active_in      = active_ff;
      ticks_in       = ticks_ff;
      start_speed_in = start_speed_ff;

      if (proc) begin
         if (!active_ff) begin
            if (start_hit) begin
               active_in      = 1'b1;
               ticks_in       = 16'd1;
               start_speed_in = speed;
            end else begin
               ticks_in = '0;
            end
         end else if (hold_hit) begin
            ticks_in = (ticks_ff < TICK_LIMIT) ? ticks_ff + 16'd1 : TICK_LIMIT;
         end else begin
            evt.fire  = emit_ok;
            active_in = 1'b0;
            ticks_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         ticks_ff       <= '0;
         start_speed_ff <= '0;
      end else begin
         active_ff      <= active_in;
         ticks_ff       <= ticks_in;
         start_speed_ff <= start_speed_in;
      end
   end

endmodule

`default_nettype wire

[design/habd_rsp_fifo.sv]
// Result queue: up to two pushes and one pop per cycle.
// Depends on habd_pkg.
`default_nettype none

module habd_rsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  habd_pkg::rsp_push_type  push,
   input  wire logic               pop,
   output habd_pkg::rsp_entry_type head,
   output logic                    not_empty,
   output logic                    room2
);
   import habd_pkg::*;

   rsp_entry_type          mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_CNT_W-1:0]   n_push;

   always_comb begin
      n_push    = RSP_CNT_W'(push.push0) + RSP_CNT_W'(push.push1);
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + n_push - RSP_CNT_W'(pop);
      not_empty = count_ff != '0;
      room2     = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
      head      = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem[wr_ptr_ff] <= push.entry0;
      end
      if (push.push1) begin
         mem[wr_ptr_ff + RSP_PTR_W'(1)] <= push.entry1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[design/harsh_accel_brake_detector.sv]
// Harsh braking / harsh acceleration event detector, top level.
// Depends on habd_pkg, habd_detector and habd_rsp_fifo.
//
// Usage:
//   req_* carries one sample per transaction (acceleration and the speed of
//   the preceding sample). rsp_* carries event transactions; a sample makes
//   zero, one or two of them, braking first, last_event set on the final one.
//   csr_* is an APB-style port holding the four threshold levels at byte
//   addresses 0, 4, 8 and 12; pready is tied high, reads return the level
//   sign-extended to 32 bits.
//   A sample is held in the input register, then passes through the
//   detector into the result queue, whose head drives rsp_*.
//   Throughput: one sample per cycle while req_stall is low; events leave one
//   per cycle while rsp_stall is low, so a sample that closes both episodes gives two events in turn.
//   The four-entry result queue absorbs that; req_stall rises only while
//   the queue has fewer than two free entries and a sample is waiting.
//   Stalling rsp_stall holds the head event and backs up into req_stall.
//   Reset (synchronous) idles both detectors, empties the queue and restores
//   the default levels.
`default_nettype none

module harsh_accel_brake_detector (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_accel_sample,
   input  wire logic [9:0]         req_speed_before,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_event_kind,
   output logic [22:0]             rsp_duration_ms,
   output logic [9:0]              rsp_start_speed,
   output logic [9:0]              rsp_end_speed,
   output logic                    rsp_last_event,

   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import habd_pkg::*;

   logic signed [15:0] brake_start_ff, brake_release_ff;
   logic signed [15:0] accel_start_ff, accel_release_ff;
   logic               csr_write;
   reg_index_type      csr_index;
   logic signed [15:0] csr_rd_level;

   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] sample_ff;
   logic [9:0]         speed_ff;
   logic               accept, proc;

   det_event_type      brake_evt, accel_evt;
   rsp_push_type       push;
   rsp_entry_type      head;
   logic               not_empty, room2;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_BRAKE_START:   csr_rd_level = brake_start_ff;
         REG_BRAKE_RELEASE: csr_rd_level = brake_release_ff;
         REG_ACCEL_START:   csr_rd_level = accel_start_ff;
         REG_ACCEL_RELEASE: csr_rd_level = accel_release_ff;
         default:           csr_rd_level = '0;
      endcase
      csr_prdata = {{16{csr_rd_level[15]}}, csr_rd_level};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_start_ff   <= BRAKE_START_RESET;
         brake_release_ff <= BRAKE_RELEASE_RESET;
         accel_start_ff   <= ACCEL_START_RESET;
         accel_release_ff <= ACCEL_RELEASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BRAKE_START:   brake_start_ff   <= csr_pwdata[15:0];
            REG_BRAKE_RELEASE: brake_release_ff <= csr_pwdata[15:0];
            REG_ACCEL_START:   accel_start_ff   <= csr_pwdata[15:0];
            REG_ACCEL_RELEASE: accel_release_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // input register; the held sample is processed once the queue has room
   assign proc      = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_accel_sample;
         speed_ff  <= req_speed_before;
      end
   end

   habd_detector u_brake (
      .clock         (clock),
      .reset         (reset),
      .kind          (KIND_BRAKE),
      .proc          (proc),
      .accel_sample  (sample_ff),
      .speed         (speed_ff),
      .start_level   (brake_start_ff),
      .release_level (brake_release_ff),
      .evt           (brake_evt)
   );

   habd_detector u_accel (
      .clock         (clock),
      .reset         (reset),
      .kind          (KIND_ACCEL),
      .proc          (proc),
      .accel_sample  (sample_ff),
      .speed         (speed_ff),
      .start_level   (accel_start_ff),
      .release_level (accel_release_ff),
      .evt           (accel_evt)
   );

   // braking goes first when both episodes close on one sample
   always_comb begin
      push.push0              = brake_evt.fire || accel_evt.fire;
      push.push1              = brake_evt.fire && accel_evt.fire;
      push.entry0.kind        = brake_evt.fire ? KIND_BRAKE : KIND_ACCEL;
      push.entry0.duration_ms = brake_evt.fire ? brake_evt.duration_ms
                                               : accel_evt.duration_ms;
      push.entry0.start_speed = brake_evt.fire ? brake_evt.start_speed
                                               : accel_evt.start_speed;
      push.entry0.end_speed   = speed_ff;
      push.entry0.last_event  = !push.push1;
      push.entry1.kind        = KIND_ACCEL;
      push.entry1.duration_ms = accel_evt.duration_ms;
      push.entry1.start_speed = accel_evt.start_speed;
      push.entry1.end_speed   = speed_ff;
      push.entry1.last_event  = 1'b1;
   end

   habd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && !rsp_stall),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   assign rsp_valid       = not_empty;
   assign rsp_event_kind  = head.kind;
   assign rsp_duration_ms = head.duration_ms;
   assign rsp_start_speed = head.start_speed;
   assign rsp_end_speed   = head.end_speed;
   assign rsp_last_event  = head.last_event;

endmodule

`default_nettype wire

[design/habd_checker.sv]
// Port-level checks of the harsh braking detector, bound to the top level.
// Depends on harsh_accel_brake_detector_assert.svh.
`default_nettype none

module habd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_event_kind,
   input wire logic [22:0] rsp_duration_ms,
   input wire logic        rsp_last_event
);
   `include "harsh_accel_brake_detector_assert.svh"

   `HABD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "events after reset")
   `HABD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `HABD_ASSERT(a_first_is_brake, clock, reset, rsp_valid && !rsp_last_event |-> !rsp_event_kind, "non-last event is not braking")
   `HABD_ASSERT(a_pair_follows, clock, reset, rsp_valid && !rsp_last_event && !rsp_stall |=> rsp_valid && rsp_event_kind, "acceleration event missing after braking")
   `HABD_ASSERT(a_min_duration, clock, reset, rsp_valid |-> rsp_duration_ms >= 23'd300, "episode too short")

endmodule

bind harsh_accel_brake_detector habd_checker u_habd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_duration_ms (rsp_duration_ms),
   .rsp_last_event  (rsp_last_event)
);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench of harsh_accel_brake_detector: random and directed samples,
// threshold levels written over the APB port, events checked against an in-bench tracker.
// Depends on habd_pkg and harsh_accel_brake_detector.
module tb_top;
   import habd_pkg::*;

   localparam int HOLD_CYCLES = 100;

   typedef struct packed {
      logic signed [15:0] accel;
      logic [9:0]         speed;
      logic [3:0]         gap;
   } sample_item_type;

   typedef enum logic [1:0] {
      ZONE_BRAKE,
      ZONE_ACCEL,
      ZONE_QUIET,
      ZONE_BOUNDARY
   } zone_type;

   logic clock;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_accel_sample = '0;
   logic [9:0]         req_speed_before = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_kind;
   logic [22:0] rsp_duration_ms;
   logic [9:0]  rsp_start_speed;
   logic [9:0]  rsp_end_speed;
   logic        rsp_last_event;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   harsh_accel_brake_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_sample (req_accel_sample),
      .req_speed_before (req_speed_before),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_start_speed  (rsp_start_speed),
      .rsp_end_speed    (rsp_end_speed),
      .rsp_last_event   (rsp_last_event),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // threshold levels as the block should hold them
   logic signed [15:0] lvl [4];

   // episode tracker state
   logic        brake_on = 1'b0;
   logic [15:0] brake_ticks = '0;
   logic [9:0]  brake_from = '0;
   logic        accel_on = 1'b0;
   logic [15:0] accel_ticks = '0;
   logic [9:0]  accel_from = '0;

   sample_item_type sample_queue [$];
   rsp_entry_type   owed_events [$];
   sample_item_type staged;
   bit              staged_busy = 1'b0;
   int              gap_left = 0;
   bit              offering = 1'b0;

   bit            req_gaps = 1'b1;
   bit            rsp_gaps = 1'b1;
   bit            hold_req = 1'b0;
   bit            hold_seen = 1'b0;
   int            hold_left = 0;
   int            stall_left = 0;
   int            cur_speed = 500;
   int            mismatch_count = 0;
   rsp_entry_type head;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      lvl[REG_BRAKE_START]   = BRAKE_START_RESET;
      lvl[REG_BRAKE_RELEASE] = BRAKE_RELEASE_RESET;
      lvl[REG_ACCEL_START]   = ACCEL_START_RESET;
      lvl[REG_ACCEL_RELEASE] = ACCEL_RELEASE_RESET;
   end

   // Runs both hysteresis detectors on one sample and queues the events it closes.
   function automatic void track_episodes(logic signed [15:0] accel, logic [9:0] speed);
      bit            brake_fire;
      bit            accel_fire;
      logic [15:0]   brake_len;
      logic [15:0]   accel_len;
      rsp_entry_type ev;
      brake_fire = 1'b0;
      accel_fire = 1'b0;
      brake_len = brake_ticks;
      accel_len = accel_ticks;
      if (!brake_on) begin
         if (accel <= lvl[REG_BRAKE_START]) begin
            brake_on = 1'b1;
            brake_ticks = 16'd1;
            brake_from = speed;
         end else begin
            brake_ticks = '0;
         end
      end else if (accel <= lvl[REG_BRAKE_RELEASE]) begin
         if (brake_ticks < TICK_LIMIT) brake_ticks = brake_ticks + 16'd1;
      end else begin
         brake_fire = ({1'b0, brake_from} > {1'b0, speed} + 11'd1);
         brake_on = 1'b0;
         brake_ticks = '0;
      end
      if (!accel_on) begin
         if (accel >= lvl[REG_ACCEL_START]) begin
            accel_on = 1'b1;
            accel_ticks = 16'd1;
            accel_from = speed;
         end else begin
            accel_ticks = '0;
         end
      end else if (accel >= lvl[REG_ACCEL_RELEASE]) begin
         if (accel_ticks < TICK_LIMIT) accel_ticks = accel_ticks + 16'd1;
      end else begin
         accel_fire = (speed > accel_from);
         accel_on = 1'b0;
         accel_ticks = '0;
      end
      if (brake_fire) begin
         ev.kind = KIND_BRAKE;
         ev.duration_ms = (23'(brake_len) + 23'd2) * TICK_MS;
         ev.start_speed = brake_from;
         ev.end_speed = speed;
         ev.last_event = !accel_fire;
         owed_events.push_back(ev);
      end
      if (accel_fire) begin
         ev.kind = KIND_ACCEL;
         ev.duration_ms = (23'(accel_len) + 23'd2) * TICK_MS;
         ev.start_speed = accel_from;
         ev.end_speed = speed;
         ev.last_event = 1'b1;
         owed_events.push_back(ev);
      end
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         staged_busy = 1'b0;
         req_valid <= 1'b0;
      end else begin
         if (offering && !req_stall) begin
            track_episodes(req_accel_sample, req_speed_before);
            offering = 1'b0;
         end
         if (!offering) begin
            if (!staged_busy && sample_queue.size() > 0) begin
               staged = sample_queue.pop_front();
               gap_left = staged.gap;
               staged_busy = 1'b1;
            end
            if (staged_busy && gap_left == 0) begin
               req_accel_sample <= staged.accel;
               req_speed_before <= staged.speed;
               offering = 1'b1;
               staged_busy = 1'b0;
            end else begin
               if (staged_busy) gap_left--;
               req_accel_sample <= 16'($urandom);
               req_speed_before <= 10'($urandom);
            end
         end
         req_valid <= offering;
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // event monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_seen = hold_req;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_events.size() == 0) begin
               $display("%0t: event transaction with none outstanding, %s %0d",
                        $time, "expected none actual kind", rsp_event_kind);
               mismatch_count++;
            end else begin
               head = owed_events.pop_front();
               check_field("event_kind", head.kind, rsp_event_kind);
               check_field("duration_ms", head.duration_ms, rsp_duration_ms);
               check_field("start_speed", head.start_speed, rsp_start_speed);
               check_field("end_speed", head.end_speed, rsp_end_speed);
               check_field("last_event", head.last_event, rsp_last_event);
            end
            stall_left = rsp_gaps ? $urandom_range(0, 8) : 0;
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_level(input reg_index_type idx, input logic signed [15:0] level);
      logic [31:0] wide;
      wide = {{16{level[15]}}, level};
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wide;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      lvl[idx] = level;
      // read it back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("level readback", wide, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic signed [15:0] clip16(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
   endfunction

   task automatic set_levels(input int brake_start, input int brake_release,
                             input int accel_start, input int accel_release);
      write_level(REG_BRAKE_START, clip16(brake_start));
      write_level(REG_BRAKE_RELEASE, clip16(brake_release));
      write_level(REG_ACCEL_START, clip16(accel_start));
      write_level(REG_ACCEL_RELEASE, clip16(accel_release));
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] draw_between(input int lo, input int hi);
      if (hi <= lo) return 16'(lo);
      return 16'(lo + int'($urandom_range(hi - lo, 0)));
   endfunction

   task automatic add_sample(input int accel, input int speed, input bit allow_gap);
      sample_item_type item;
      item.accel = 16'(accel);
      item.speed = 10'(speed);
      item.gap = allow_gap ? 4'($urandom_range(0, 8)) : 4'd0;
      sample_queue.push_back(item);
   endtask

   // Runs of samples inside one detector's zone form episodes; a zone change ends them.
   task automatic queue_random(input int count);
      zone_type           zone;
      int                 run_left;
      bit                 calm;
      int                 brake_top;
      int                 accel_floor;
      logic signed [15:0] a;
      run_left = 0;
      zone = ZONE_QUIET;
      calm = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: zone = ZONE_BRAKE;
               4, 5, 6, 7: zone = ZONE_ACCEL;
               8: zone = ZONE_QUIET;
               default: zone = ZONE_BOUNDARY;
            endcase
            run_left = $urandom_range(1, 12);
            calm = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         brake_top = (lvl[REG_BRAKE_START] < lvl[REG_BRAKE_RELEASE]) ?
                     lvl[REG_BRAKE_START] : lvl[REG_BRAKE_RELEASE];
         accel_floor = (lvl[REG_ACCEL_START] > lvl[REG_ACCEL_RELEASE]) ?
                       lvl[REG_ACCEL_START] : lvl[REG_ACCEL_RELEASE];
         case (zone)
            ZONE_BRAKE: begin
               a = draw_between(-32768, brake_top);
               cur_speed -= $urandom_range(0, 40);
            end
            ZONE_ACCEL: begin
               a = draw_between(accel_floor, 32767);
               cur_speed += $urandom_range(0, 40);
            end
            ZONE_QUIET: begin
               a = 16'($urandom);
               if ($urandom_range(0, 3) == 0) cur_speed = $urandom_range(0, 1023);
            end
            default: begin
               case ($urandom_range(0, 6))
                  0: a = -16'sd32768;
                  1: a = 16'sd32767;
                  2: a = '0;
                  3: a = -16'sd1;
                  4: a = lvl[$urandom_range(0, 3)];
                  5: a = clip16(int'(lvl[$urandom_range(0, 3)]) + 1);
                  default: a = clip16(int'(lvl[$urandom_range(0, 3)]) - 1);
               endcase
            end
         endcase
         if ($urandom_range(0, 15) == 0) cur_speed = $urandom_range(0, 1) * 1023;
         if (cur_speed < 0) cur_speed = 0;
         if (cur_speed > 1023) cur_speed = 1023;
         add_sample(a, cur_speed, req_gaps && !calm);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_queue.size() > 0 || staged_busy || offering || owed_events.size() > 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default levels: boundaries, speed-change limits, both kinds
      add_sample(-32768, 1023, 1);
      add_sample(-768, 700, 1);
      add_sample(-512, 600, 1);
      add_sample(-511, 0, 1);
      add_sample(-768, 10, 1);
      add_sample(-511, 9, 1);      // fell by exactly one: no event
      add_sample(-768, 10, 1);
      add_sample(0, 8, 1);
      add_sample(768, 5, 1);
      add_sample(512, 6, 1);
      add_sample(511, 6, 1);
      add_sample(32767, 100, 1);
      add_sample(511, 100, 1);     // no speed gain: no event
      add_sample(-767, 0, 1);
      add_sample(767, 0, 1);
      add_sample(32767, 0, 1);
      add_sample(-32768, 1023, 1);
      add_sample(32767, 0, 1);
      wait_idle();

      // receiver holds off while samples keep coming and closing episodes
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      hold_req = ~hold_req;
      for (int n = 0; n < 40; n++)
         add_sample((n % 2) ? -32768 : 32767, (n % 2) ? 1023 : 0, 0);
      wait_idle();

      // overlapping levels so both detectors can be active and close together
      set_levels(-100, 0, -50, 100);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      add_sample(-200, 600, 1);
      add_sample(-20, 300, 1);
      add_sample(50, 400, 1);
      add_sample(-200, 600, 1);
      add_sample(-20, 300, 1);
      add_sample(50, 299, 1);
      add_sample(-200, 100, 1);
      add_sample(-20, 50, 1);
      add_sample(50, 99, 1);
      wait_idle();

      // both episodes run long back to back and close on one sample
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      add_sample(-200, 900, 0);
      add_sample(-20, 500, 0);
      for (int n = 0; n < 30; n++) add_sample(-20, $urandom_range(0, 1023), 0);
      add_sample(50, 600, 0);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         int mid;
         int brake_start;
         int accel_start;
         case (p)
            0: ;
            1: set_levels(32767, -32768, -32768, 32767);
            2: set_levels(-32768, 32767, 32767, -32768);
            default: begin
               mid = int'($urandom_range(0, 40000)) - 20000;
               brake_start = mid - int'($urandom_range(0, 3000));
               accel_start = mid + int'($urandom_range(0, 3000));
               set_levels(brake_start, brake_start + int'($urandom_range(0, 1500)) - 300,
                          accel_start, accel_start - int'($urandom_range(0, 1500)) + 300);
            end
         endcase
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         queue_random((p == 2) ? 150 : 180);
         wait_idle();
      end

      if (mismatch_count == 0 && owed_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
